[rtl/coordinate_search_minimizer_assert.svh]
// assertion macros for the coordinate search minimizer
`ifndef COORDINATE_SEARCH_MINIMIZER_ASSERT_SVH
`define COORDINATE_SEARCH_MINIMIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define CSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define CSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSM_ASSERT_IMP(lbl, ante, cons, msg)
`define CSM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/csm_pkg.sv]
`default_nettype none

package csm_pkg;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_VALUE = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_NEG  = 2'd2,
    ALU_HALF = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         index;
    logic signed [31:0] coord_value;
    logic signed [31:0] step_value;
    logic [30:0]        limit_value;
    logic signed [31:0] function_value;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         index_res;
    logic signed [31:0] coord_value_res;
    logic signed [31:0] step_value_res;
    logic signed [31:0] best_value;
    logic               last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/csm_sat_alu.sv]
`default_nettype none

module csm_sat_alu #(
  parameter int VB = 32
) (
  input  csm_pkg::alu_op_t    op,
  input  logic signed [VB-1:0] a,
  input  logic signed [VB-1:0] b,
  output logic signed [VB-1:0] y
);
  import csm_pkg::*;

  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = ~VMAX;

  logic signed [VB:0] wa;
  logic signed [VB:0] wb;
  logic signed [VB:0] sum;
  logic signed [VB:0] dif;
  logic [VB:0]        rnd;

  assign wa  = {a[VB-1], a};
  assign wb  = {b[VB-1], b};
  assign sum = wa + wb;
  assign dif = wa - wb;
  // bias negatives by one so the shift rounds toward zero
  assign rnd = wa + (VB+1)'(a[VB-1]);

  always_comb begin
    unique case (op)
      ALU_ADD: begin
        if (sum[VB] != sum[VB-1]) y = sum[VB] ? VMIN : VMAX;
        else y = sum[VB-1:0];
      end
      ALU_SUB: begin
        if (dif[VB] != dif[VB-1]) y = dif[VB] ? VMIN : VMAX;
        else y = dif[VB-1:0];
      end
      ALU_NEG: y = (a == VMIN) ? VMAX : -a;
      ALU_HALF: y = rnd[VB:1];
    endcase
  end

endmodule

`default_nettype wire

[rtl/coordinate_search_minimizer.sv]
// coordinate search minimizer: sequencer for a per-coordinate line search
// with the objective evaluated outside the block.
// input channel: an item (in_item) is taken at a clock edge with start high
// and busy low. opcode load writes one coordinate's start value, step and
// limit in that cycle. start emits the stored point. value returns the
// objective at the last emitted point and drives the step rule.
// result channel: out_valid marks each item for one cycle; a point comes out
// as one item per active coordinate in index order, last set on the final
// one, kind set when the run has finished. results cannot be held off.
// timing: every arithmetic step goes through one saturating add/sub/neg/
// halve unit, one operation a cycle, and each coordinate access is a
// registered memory read. a value item is stepped first (an improving
// move, a reversal, or a closed coordinate and the next one's first step,
// passing over skipped coordinates) and the point is then emitted; busy is
// high from the accepted item to its last read, so no item is taken meanwhile.
// config (params_in_use, stride_limit) is written through cfg_we at any
// edge; it is meant to change only between runs.
// reset: synchronous, clears the sequencer, best value and counters; the
// coordinate stores hold nothing until loaded.
`default_nettype none

`include "coordinate_search_minimizer_assert.svh"

module coordinate_search_minimizer #(
  parameter int MAX_COORDS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  csm_pkg::in_item_t                    in_item,
  output logic                                 out_valid,
  output csm_pkg::out_item_t                   out_item,
  input  logic                                 cfg_we,
  input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [csm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import csm_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int CW    = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int NW    = $clog2(MAX_COORDS + 1);
  localparam int EXT_W = (VB > 32) ? VB : 32;
  localparam int MW    = (VB > 31) ? VB : 31;

  localparam logic signed [EXT_W-1:0] VMAX_E = EXT_W'($signed({1'b0, {(VB-1){1'b1}}}));
  localparam logic signed [EXT_W-1:0] VMIN_E = ~VMAX_E;

  localparam logic [CFG_IDX_W-1:0] REG_PARAMS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_LIMIT  = 1'd1;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_RD       = 12'b0000_0000_0010,
    S_FETCH    = 12'b0000_0000_0100,
    S_VAL      = 12'b0000_0000_1000,
    S_REV1     = 12'b0000_0001_0000,
    S_REV2     = 12'b0000_0010_0000,
    S_RUN_ADD  = 12'b0000_0100_0000,
    S_HALF     = 12'b0000_1000_0000,
    S_WB       = 12'b0001_0000_0000,
    S_ADV_CHK  = 12'b0010_0000_0000,
    S_ADV_EVAL = 12'b0100_0000_0000,
    S_EMIT     = 12'b1000_0000_0000
  } state_t;

  typedef enum logic [4:0] {
    P_IDLE       = 5'b00001,
    P_WAIT_START = 5'b00010,
    P_WAIT_FWD   = 5'b00100,
    P_WAIT_REV   = 5'b01000,
    P_WAIT_RUN   = 5'b10000
  } phase_t;

  function automatic logic [VB-1:0] clamp_in(input logic signed [31:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > VMAX_E) clamp_in = VMAX_E[VB-1:0];
    else if (e < VMIN_E) clamp_in = VMIN_E[VB-1:0];
    else clamp_in = e[VB-1:0];
  endfunction

  function automatic logic signed [31:0] to_out32(input logic signed [VB-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    to_out32 = e[31:0];
  endfunction

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [NW-1:0]        cur_r, cur_nxt;
  logic [NW-1:0]        skip_r, skip_nxt;
  logic [15:0]          move_r, move_nxt;
  logic signed [31:0]   best_r, best_nxt;
  logic                 pass_r, pass_nxt;
  logic                 ctx_adv_r, ctx_adv_nxt;
  logic                 wb_adv_r, wb_adv_nxt;
  logic                 kind_r, kind_nxt;
  logic [CW-1:0]        e_r, e_nxt;
  logic signed [31:0]   f_r, f_nxt;
  logic signed [VB-1:0] c_r, c_nxt;
  logic signed [VB-1:0] s_r, s_nxt;
  logic [30:0]          lim_r, lim_nxt;
  logic [4:0]           params_r, params_nxt;
  logic [15:0]          stride_r, stride_nxt;

  logic [VB-1:0] coord_mem [MAX_COORDS];
  logic [VB-1:0] step_mem  [MAX_COORDS];
  logic [30:0]   limit_mem [MAX_COORDS];

  logic [CW-1:0]        raddr;
  logic [CW-1:0]        waddr;
  logic                 mem_we;
  logic                 lim_we;
  logic [VB-1:0]        wcoord;
  logic [VB-1:0]        wstep;
  logic [VB-1:0]        rd_coord_r;
  logic [VB-1:0]        rd_step_r;
  logic [30:0]          rd_lim_r;

  logic                 rd_pend_r;
  logic [CW-1:0]        rd_idx_r;
  logic                 rd_last_r;
  logic                 rd_kind_r;
  logic signed [31:0]   rd_best_r;
  logic                 out_valid_r;
  out_item_t            out_item_r, out_item_nxt;

  alu_op_t              alu_op;
  logic signed [VB-1:0] alu_a;
  logic signed [VB-1:0] alu_b;
  logic signed [VB-1:0] alu_y;

  logic [NW-1:0]        n_c;
  logic [NW-1:0]        n_m1;
  logic [VB-1:0]        mag;
  logic                 mag_lt;
  logic                 in_acc;

  csm_sat_alu #(.VB(VB)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  // active coordinate count, zero taken as one, capped at MAX_COORDS
  always_comb begin
    if (params_r == 5'd0) n_c = NW'(1);
    else if (32'(params_r) > MAX_COORDS) n_c = NW'(MAX_COORDS);
    else n_c = NW'(params_r);
  end
  assign n_m1 = n_c - 1'b1;

  assign mag    = s_r[VB-1] ? VB'(-s_r) : VB'(s_r);
  assign mag_lt = MW'(mag) < MW'(lim_r);

  assign busy   = (state_r != S_IDLE);
  assign in_acc = start && !busy;

  always_comb begin
    state_nxt   = state_r;
    phase_nxt   = phase_r;
    cur_nxt     = cur_r;
    skip_nxt    = skip_r;
    move_nxt    = move_r;
    best_nxt    = best_r;
    pass_nxt    = pass_r;
    ctx_adv_nxt = ctx_adv_r;
    wb_adv_nxt  = wb_adv_r;
    kind_nxt    = kind_r;
    e_nxt       = e_r;
    f_nxt       = f_r;
    c_nxt       = c_r;
    s_nxt       = s_r;
    lim_nxt     = lim_r;
    alu_op      = ALU_ADD;
    alu_a       = c_r;
    alu_b       = s_r;
    raddr       = cur_r[CW-1:0];
    waddr       = cur_r[CW-1:0];
    mem_we      = 1'b0;
    lim_we      = 1'b0;
    wcoord      = c_r;
    wstep       = s_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_item.opcode)
            OP_LOAD: begin
              if (32'(in_item.index) < MAX_COORDS) begin
                waddr  = CW'(in_item.index);
                wcoord = clamp_in(in_item.coord_value);
                wstep  = clamp_in(in_item.step_value);
                mem_we = 1'b1;
                lim_we = 1'b1;
              end
            end
            OP_START: begin
              cur_nxt   = '0;
              skip_nxt  = '0;
              move_nxt  = '0;
              phase_nxt = P_WAIT_START;
              kind_nxt  = 1'b0;
              e_nxt     = '0;
              state_nxt = S_EMIT;
            end
            OP_VALUE: begin
              f_nxt = in_item.function_value;
              priority if (phase_r == P_IDLE) begin
                // nothing to do with a value outside a run
              end else if (phase_r == P_WAIT_START) begin
                best_nxt  = in_item.function_value;
                cur_nxt   = '0;
                skip_nxt  = '0;
                pass_nxt  = 1'b0;
                state_nxt = S_ADV_CHK;
              end else if (32'(cur_r) >= MAX_COORDS) begin
                phase_nxt = P_IDLE;
              end else begin
                ctx_adv_nxt = 1'b0;
                state_nxt   = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: state_nxt = S_FETCH;
      S_FETCH: begin
        c_nxt     = rd_coord_r;
        s_nxt     = rd_step_r;
        lim_nxt   = rd_lim_r;
        state_nxt = ctx_adv_r ? S_ADV_EVAL : S_VAL;
      end
      S_VAL: begin
        priority if (phase_r == P_WAIT_FWD && f_r > best_r) begin
          // first step went uphill: turn around and jump past the start
          alu_op    = ALU_NEG;
          alu_a     = s_r;
          s_nxt     = alu_y;
          phase_nxt = P_WAIT_REV;
          state_nxt = S_REV1;
        end else if (f_r < best_r) begin
          move_nxt = move_r + 16'd1;
          if (move_r == stride_r) begin
            move_nxt = '0;
            alu_op   = ALU_ADD;
            alu_a    = s_r;
            alu_b    = s_r;
            s_nxt    = alu_y;
          end
          best_nxt  = f_r;
          phase_nxt = P_WAIT_RUN;
          state_nxt = S_RUN_ADD;
        end else begin
          // no gain: back off the last move, then halve the step
          alu_op    = ALU_SUB;
          c_nxt     = alu_y;
          state_nxt = S_HALF;
        end
      end
      S_REV1: begin
        c_nxt     = alu_y;
        state_nxt = S_REV2;
      end
      S_REV2: begin
        c_nxt      = alu_y;
        wb_adv_nxt = 1'b0;
        state_nxt  = S_WB;
      end
      S_RUN_ADD: begin
        c_nxt      = alu_y;
        wb_adv_nxt = 1'b0;
        state_nxt  = S_WB;
      end
      S_HALF: begin
        alu_op     = ALU_HALF;
        alu_a      = s_r;
        s_nxt      = alu_y;
        wb_adv_nxt = 1'b1;
        state_nxt  = S_WB;
      end
      S_WB: begin
        mem_we = 1'b1;
        if (wb_adv_r) begin
          cur_nxt   = cur_r + 1'b1;
          pass_nxt  = 1'b0;
          state_nxt = S_ADV_CHK;
        end else begin
          kind_nxt  = 1'b0;
          e_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_ADV_CHK: begin
        priority if (cur_r < n_c) begin
          ctx_adv_nxt = 1'b1;
          state_nxt   = S_RD;
        end else if (skip_r >= n_c) begin
          // whole sweep skipped: run is over
          phase_nxt = P_IDLE;
          kind_nxt  = 1'b1;
          e_nxt     = '0;
          state_nxt = S_EMIT;
        end else if (!pass_r) begin
          cur_nxt  = '0;
          skip_nxt = '0;
          pass_nxt = 1'b1;
        end else begin
          phase_nxt = P_IDLE;
          state_nxt = S_IDLE;
        end
      end
      S_ADV_EVAL: begin
        if (mag_lt) begin
          skip_nxt  = skip_r + 1'b1;
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_ADV_CHK;
        end else begin
          c_nxt      = alu_y;
          move_nxt   = '0;
          phase_nxt  = P_WAIT_FWD;
          wb_adv_nxt = 1'b0;
          state_nxt  = S_WB;
        end
      end
      S_EMIT: begin
        raddr = e_r;
        if (e_r == n_m1[CW-1:0]) state_nxt = S_IDLE;
        else e_nxt = e_r + 1'b1;
      end
    endcase
  end

  // config writes
  always_comb begin
    params_nxt = params_r;
    stride_nxt = stride_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PARAMS_IN_USE: params_nxt = cfg_wdata[4:0];
        REG_STRIDE_LIMIT:  stride_nxt = cfg_wdata;
      endcase
    end
  end

  always_comb begin
    out_item_nxt.kind            = rd_kind_r;
    out_item_nxt.index_res       = 4'(rd_idx_r);
    out_item_nxt.coord_value_res = to_out32(rd_coord_r);
    out_item_nxt.step_value_res  = to_out32(rd_step_r);
    out_item_nxt.best_value      = rd_best_r;
    out_item_nxt.last            = rd_last_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      coord_mem[waddr] <= wcoord;
      step_mem[waddr]  <= wstep;
    end
    if (lim_we) limit_mem[waddr] <= in_item.limit_value;
    rd_coord_r <= coord_mem[raddr];
    rd_step_r  <= step_mem[raddr];
    rd_lim_r   <= limit_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_IDLE;
      cur_r       <= '0;
      skip_r      <= '0;
      move_r      <= '0;
      best_r      <= '0;
      pass_r      <= 1'b0;
      ctx_adv_r   <= 1'b0;
      wb_adv_r    <= 1'b0;
      kind_r      <= 1'b0;
      e_r         <= '0;
      params_r    <= 5'd16;
      stride_r    <= 16'd10;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      skip_r      <= skip_nxt;
      move_r      <= move_nxt;
      best_r      <= best_nxt;
      pass_r      <= pass_nxt;
      ctx_adv_r   <= ctx_adv_nxt;
      wb_adv_r    <= wb_adv_nxt;
      kind_r      <= kind_nxt;
      e_r         <= e_nxt;
      params_r    <= params_nxt;
      stride_r    <= stride_nxt;
      rd_pend_r   <= (state_r == S_EMIT);
      out_valid_r <= rd_pend_r;
    end
  end

  // working registers and the emit read stage
  always_ff @(posedge clk) begin
    f_r        <= f_nxt;
    c_r        <= c_nxt;
    s_r        <= s_nxt;
    lim_r      <= lim_nxt;
    rd_idx_r   <= e_r;
    rd_last_r  <= (e_r == n_m1[CW-1:0]);
    rd_kind_r  <= kind_r;
    rd_best_r  <= best_r;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CSM_ASSERT_IMP(a_rd_in_range, state_r == S_RD, cur_r < n_c, "coordinate read past active count")
  `CSM_ASSERT_IMP(a_skip_le_cur, 1'b1, skip_r <= cur_r, "skip count ran ahead of coordinate")
  `CSM_ASSERT_NXT(a_last_gap, out_valid_r && out_item_r.last, !out_valid_r, "result after last item")

endmodule

`default_nettype wire

[verif/coordinate_search_minimizer_test.sv]
`default_nettype none

module coordinate_search_minimizer_test;
  import csm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COORDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'b1;
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_FINAL = 1'b1;
  localparam int NUM_COORDS = 16;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int RUN_CAP = 40;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic [2:0] {
    SEARCH_IDLE, AWAIT_FIRST, AWAIT_FWD, AWAIT_REV, AWAIT_RUN
  } search_phase_t;

  // tracks the step rule item by item and holds the points it predicts
  class step_rule_tracker;
    longint coord_mem[NUM_COORDS];
    longint step_mem[NUM_COORDS];
    longint limit_mem[NUM_COORDS];
    longint best;
    int unsigned cur_coord;
    int unsigned skip_count;
    logic [15:0] move_count;
    search_phase_t phase;
    logic [4:0] coords_in_use;
    logic [15:0] doubling_stride;
    out_item_t expected_points[$];
    int unsigned error_count;
    int unsigned point_count;
    int unsigned final_count;

    function new();
      foreach (coord_mem[i]) begin
        coord_mem[i] = 0;
        step_mem[i] = 0;
        limit_mem[i] = 0;
      end
      best = 0;
      cur_coord = 0;
      skip_count = 0;
      move_count = '0;
      phase = SEARCH_IDLE;
      coords_in_use = 5'd16;
      doubling_stride = 16'd10;
      error_count = 0;
      point_count = 0;
      final_count = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > VMAX) return VMAX;
      if (v < VMIN) return VMIN;
      return v;
    endfunction

    function int unsigned active_count();
      if (coords_in_use == 0) return 1;
      if (coords_in_use > NUM_COORDS) return NUM_COORDS;
      return coords_in_use;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == CFG_COORDS) coords_in_use = data[4:0];
      else doubling_stride = data;
    endfunction

    function void emit_point(logic kind);
      int unsigned n;
      int unsigned i;
      out_item_t r;
      n = active_count();
      for (i = 0; i < n; i++) begin
        r.kind = kind;
        r.index_res = i[3:0];
        r.coord_value_res = coord_mem[i][31:0];
        r.step_value_res = step_mem[i][31:0];
        r.best_value = best[31:0];
        r.last = (i + 1 == n);
        expected_points.push_back(r);
      end
    endfunction

    // look for the next coordinate to search, or finish the run
    function void advance();
      int unsigned n;
      longint mag;
      n = active_count();
      for (int pass = 0; pass < 2; pass++) begin
        while (cur_coord < n) begin
          mag = (step_mem[cur_coord] < 0) ? -step_mem[cur_coord] : step_mem[cur_coord];
          if (mag < limit_mem[cur_coord]) begin
            skip_count++;
            cur_coord++;
          end else begin
            coord_mem[cur_coord] = clamp32(coord_mem[cur_coord] + step_mem[cur_coord]);
            move_count = '0;
            phase = AWAIT_FWD;
            emit_point(KIND_POINT);
            return;
          end
        end
        if (skip_count >= n) begin
          phase = SEARCH_IDLE;
          emit_point(KIND_FINAL);
          return;
        end
        skip_count = 0;
        cur_coord = 0;
      end
      phase = SEARCH_IDLE;
    endfunction

    function void follow_run(longint f, int unsigned i);
      logic [15:0] prior;
      longint d;
      if (f < best) begin
        prior = move_count;
        move_count = move_count + 16'd1;
        if (prior == doubling_stride) begin
          move_count = '0;
          step_mem[i] = clamp32(step_mem[i] * 2);
        end
        best = f;
        coord_mem[i] = clamp32(coord_mem[i] + step_mem[i]);
        phase = AWAIT_RUN;
        emit_point(KIND_POINT);
        return;
      end
      // no better: halve toward zero and back off the last move
      d = step_mem[i];
      step_mem[i] = d / 2;
      coord_mem[i] = clamp32(coord_mem[i] - d);
      cur_coord++;
      advance();
    endfunction

    function void note_input(in_item_t it);
      longint f;
      int unsigned i;
      case (it.opcode)
        OP_LOAD: begin
          coord_mem[it.index] = it.coord_value;
          step_mem[it.index] = it.step_value;
          limit_mem[it.index] = it.limit_value;
        end
        OP_START: begin
          cur_coord = 0;
          skip_count = 0;
          move_count = '0;
          phase = AWAIT_FIRST;
          emit_point(KIND_POINT);
        end
        OP_VALUE: begin
          f = it.function_value;
          i = cur_coord;
          if (phase == SEARCH_IDLE) return;
          if (phase == AWAIT_FIRST) begin
            best = f;
            cur_coord = 0;
            skip_count = 0;
            advance();
            return;
          end
          if (i >= NUM_COORDS) begin
            phase = SEARCH_IDLE;
            return;
          end
          if (phase == AWAIT_FWD && f > best) begin
            step_mem[i] = clamp32(-step_mem[i]);
            coord_mem[i] = clamp32(clamp32(coord_mem[i] + step_mem[i]) + step_mem[i]);
            phase = AWAIT_REV;
            emit_point(KIND_POINT);
            return;
          end
          follow_run(f, i);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned idx, logic [31:0] want,
                                logic [31:0] got);
      if (got !== want) begin
        error_count++;
        $display("%0t: %s mismatch at coordinate %0d, expected %h, actual %h",
                 $time, name, idx, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_points.size() == 0) begin
        error_count++;
        $display("%0t: result with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_points.pop_front();
      if (want.kind == KIND_FINAL) final_count++;
      else point_count++;
      compare_field("kind", want.index_res, want.kind, got.kind);
      compare_field("index", want.index_res, want.index_res, got.index_res);
      compare_field("coord", want.index_res, want.coord_value_res, got.coord_value_res);
      compare_field("step", want.index_res, want.step_value_res, got.step_value_res);
      compare_field("best", want.index_res, want.best_value, got.best_value);
      compare_field("last", want.index_res, want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  step_rule_tracker tracker;
  longint goal[NUM_COORDS];
  longint bias;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned ignored_items;
  int unsigned config_writes;

  logic [4:0] coord_plan[8] = '{5'd2, 5'd0, 5'd3, 5'd31, 5'd1, 5'd16, 5'd17, 5'd2};
  logic [15:0] stride_plan[8] = '{16'd0, 16'd65535, 16'd5, 16'd2, 16'd0, 16'd65535,
                                  16'd3, 16'd10};

  coordinate_search_minimizer uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_item);
  end

  initial begin
    #3000000;
    $display("coordinate_search_minimizer_test failed");
    $finish;
  end

  function automatic in_item_t random_item();
    in_item_t it;
    it.opcode = 2'($urandom);
    it.index = 4'($urandom);
    it.coord_value = $urandom;
    it.step_value = $urandom;
    it.limit_value = 31'($urandom);
    it.function_value = $urandom;
    return it;
  endfunction

  // objective the search is chasing: scaled distance to the goal point plus a bias
  function automatic logic signed [31:0] objective();
    longint total;
    longint diff;
    int unsigned i;
    total = 0;
    for (i = 0; i < tracker.active_count(); i++) begin
      diff = tracker.coord_mem[i] - goal[i];
      total += (diff < 0) ? -diff : diff;
    end
    total = (total >>> 4) + bias;
    return 32'(tracker.clamp32(total));
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(5) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    tracker.note_input(it);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (tracker.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_config(logic [4:0] coords, logic [15:0] stride);
    logic [15:0] coord_word;
    coord_word = {11'($urandom), coords};
    cfg_we <= 1'b1;
    cfg_index <= CFG_COORDS;
    cfg_wdata <= coord_word;
    @(posedge clk);
    cfg_index <= CFG_STRIDE;
    cfg_wdata <= stride;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(CFG_COORDS, coord_word);
    tracker.set_register(CFG_STRIDE, stride);
    config_writes++;
  endtask

  task automatic load_exact(logic [3:0] idx, logic [31:0] c, logic [31:0] s,
                            logic [30:0] lim);
    in_item_t it;
    it = random_item();
    it.opcode = OP_LOAD;
    it.index = idx;
    it.coord_value = c;
    it.step_value = s;
    it.limit_value = lim;
    send_item(it);
  endtask

  // a coordinate with a sensible step and limit, or fully random fields
  task automatic load_coordinate(int unsigned idx, bit wild);
    in_item_t it;
    longint mag;
    longint c;
    longint s;
    int k;
    it = random_item();
    it.opcode = OP_LOAD;
    it.index = idx[3:0];
    if (!wild) begin
      mag = $urandom_range(32'h100, 32'h40000);
      s = ($urandom_range(1) != 0) ? -mag : mag;
      c = longint'($urandom_range(0, 32'h200000)) - 32'h100000;
      k = int'($urandom_range(0, 4)) - 2;
      it.coord_value = c[31:0];
      it.step_value = s[31:0];
      it.limit_value = ($urandom_range(29) == 0) ? 31'd0 : 31'(mag >> $urandom_range(1, 2));
      goal[idx] = c + s * k + $urandom_range(0, 255);
    end
    send_item(it);
  endtask

  task automatic send_start();
    in_item_t it;
    it = random_item();
    it.opcode = OP_START;
    send_item(it);
  endtask

  task automatic send_value(logic [31:0] f);
    in_item_t it;
    it = random_item();
    it.opcode = OP_VALUE;
    it.function_value = f;
    send_item(it);
  endtask

  task automatic send_ignored();
    in_item_t it;
    it = random_item();
    if (tracker.phase == SEARCH_IDLE && $urandom_range(1) == 0) it.opcode = OP_VALUE;
    else it.opcode = OP_UNUSED;
    send_item(it);
    ignored_items++;
  endtask

  task automatic run_episode(inout int unsigned plan_idx);
    int unsigned n;
    int unsigned i;
    int unsigned steps;
    int unsigned roll;
    logic [31:0] f;
    if (tracker.phase == SEARCH_IDLE) begin
      drain_results();
      if (plan_idx < 8) begin
        write_config(coord_plan[plan_idx], stride_plan[plan_idx]);
        plan_idx++;
      end else begin
        write_config(($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 4)),
                     ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)));
      end
    end
    if ($urandom_range(5) == 0) send_ignored();
    n = tracker.active_count();
    bias = -longint'($urandom_range(0, 32'h40000000));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0) load_coordinate(i, 1'b0);
    end
    if ($urandom_range(6) == 0) load_coordinate($urandom_range(0, NUM_COORDS - 1), 1'b1);
    send_start();
    steps = 0;
    while (tracker.phase != SEARCH_IDLE && steps < RUN_CAP) begin
      roll = $urandom_range(99);
      if (roll < 3) load_coordinate($urandom_range(0, n - 1), 1'b0);
      else if (roll < 5) send_start();
      else begin
        if (roll < 12) f = $urandom;
        else if (roll < 19) f = tracker.best[31:0];
        else f = objective();
        send_value(f);
      end
      steps++;
    end
  endtask

  initial begin
    int unsigned plan_idx;
    int unsigned i;
    in_item_t it;
    tracker = new();
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    ignored_items = 0;
    config_writes = 0;
    plan_idx = 0;
    bias = 0;
    foreach (goal[j]) goal[j] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_config(5'd16, 16'd1);

    // value while idle and the unused opcode, both dropped
    it = '1;
    it.opcode = OP_VALUE;
    it.function_value = 32'h8000_0000;
    send_item(it);
    ignored_items++;
    it = '1;
    it.opcode = OP_UNUSED;
    send_item(it);
    ignored_items++;

    // saturating forward step, most negative step, odd step, zero limit
    load_exact(4'd0, 32'h7FFF_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    load_exact(4'd1, 32'h8000_0000, 32'h8000_0000, 31'd1);
    load_exact(4'd2, 32'h0000_0000, 32'h0000_0003, 31'd0);
    for (i = 3; i < NUM_COORDS; i++) begin
      load_exact(i[3:0], i << 16, 32'h0000_8000, 31'h0001_0000);
    end
    send_start();
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'h8000_0000);   // equal to best: closes coordinate 0
    send_value(32'h7FFF_FFFF);   // worse: reverse the most negative step
    send_value(32'h8000_0000);
    send_value(32'h8000_0001);   // worse on the odd step
    send_value(32'h8000_0000);   // halving a negative odd step

    while (items_sent < 150) run_episode(plan_idx);

    drain_results();
    $display("sent %0d items (%0d dropped by the block) over %0d register settings",
             items_sent, ignored_items, config_writes);
    $display("checked %0d point items and %0d final items",
             tracker.point_count, tracker.final_count);
    if (tracker.error_count == 0) begin
      $display("coordinate_search_minimizer_test passed");
    end else begin
      $display("coordinate_search_minimizer_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
